[sv/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the readout header checker modules.
// ----------------------------------------------------------------------------
package rhc_pkg;

   // Datagram size limits in bytes.
   localparam logic [13:0] SIZE_MIN = 14'd5;
   localparam logic [13:0] SIZE_MAX = 14'd8972;

   // Cookie carried little-endian in header bytes two to four.
   localparam logic [23:0] COOKIE_VALUE = 24'h535345;

   // Required value of the pad byte and of the version byte.
   localparam logic [7:0] PAD_VALUE     = 8'h00;
   localparam logic [7:0] VERSION_VALUE = 8'h00;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_BUFFER = 2'd1,
      ST_SIZE_ERR  = 2'd2,
      ST_HDR_ERR   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CAUSE_NONE    = 4'd0,
      CAUSE_BUFFER  = 4'd1,
      CAUSE_SIZE    = 4'd2,
      CAUSE_PAD     = 4'd3,
      CAUSE_VERSION = 4'd4,
      CAUSE_COOKIE  = 4'd5,
      CAUSE_LENGTH  = 4'd6,
      CAUSE_TYPE    = 4'd7,
      CAUSE_QUEUE   = 4'd8
   } cause_type;

   // Outcome of the header checks for one datagram.
   typedef struct packed {
      logic        accept;
      status_type  status;
      cause_type   cause;
      logic [15:0] payload_length;
   } verdict_type;

endpackage

[sv/rhc_ram.sv]
// ----------------------------------------------------------------------------
// rhc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rhc_check.sv]
// ----------------------------------------------------------------------------
// rhc_check
// Ordered header checks for one datagram; the first failing check decides.
// ----------------------------------------------------------------------------
module rhc_check #(
   parameter int QUEUE_COUNT  = 32,
   parameter int HEADER_BYTES = 30
) (
   input  logic                      buffer_present,
   input  logic [13:0]               packet_size,
   input  logic [7:0]                pad_byte,
   input  logic [7:0]                version_byte,
   input  logic [23:0]               cookie_word,
   input  logic [7:0]                packet_type,
   input  logic [15:0]               total_length,
   input  logic [7:0]                queue_index,
   input  logic [7:0]                expected_type,
   output rhc_pkg::verdict_type      verdict
);

   localparam logic [13:0] HDR_SIZE = 14'(HEADER_BYTES);
   localparam logic [15:0] HDR_LEN  = 16'(HEADER_BYTES);
   localparam logic [8:0]  Q_LIMIT  = 9'(QUEUE_COUNT);

   always_comb begin
      verdict.accept         = 1'b0;
      verdict.payload_length = '0;
      if (!buffer_present || packet_size == '0) begin
         verdict.status = rhc_pkg::ST_NO_BUFFER;
         verdict.cause  = rhc_pkg::CAUSE_BUFFER;
      end else if (packet_size < rhc_pkg::SIZE_MIN || packet_size > rhc_pkg::SIZE_MAX) begin
         verdict.status = rhc_pkg::ST_SIZE_ERR;
         verdict.cause  = rhc_pkg::CAUSE_SIZE;
      end else if (pad_byte != rhc_pkg::PAD_VALUE) begin
         verdict.status = rhc_pkg::ST_HDR_ERR;
         verdict.cause  = rhc_pkg::CAUSE_PAD;
      end else if (version_byte != rhc_pkg::VERSION_VALUE) begin
         verdict.status = rhc_pkg::ST_HDR_ERR;
         verdict.cause  = rhc_pkg::CAUSE_VERSION;
      end else if (cookie_word != rhc_pkg::COOKIE_VALUE) begin
         verdict.status = rhc_pkg::ST_HDR_ERR;
         verdict.cause  = rhc_pkg::CAUSE_COOKIE;
      end else if (packet_size < HDR_SIZE) begin
         verdict.status = rhc_pkg::ST_SIZE_ERR;
         verdict.cause  = rhc_pkg::CAUSE_SIZE;
      end else if ({2'b00, packet_size} < total_length || total_length < HDR_LEN) begin
         verdict.status = rhc_pkg::ST_SIZE_ERR;
         verdict.cause  = rhc_pkg::CAUSE_LENGTH;
      end else if (packet_type != expected_type) begin
         verdict.status = rhc_pkg::ST_HDR_ERR;
         verdict.cause  = rhc_pkg::CAUSE_TYPE;
      end else if ({1'b0, queue_index} >= Q_LIMIT) begin
         verdict.status = rhc_pkg::ST_HDR_ERR;
         verdict.cause  = rhc_pkg::CAUSE_QUEUE;
      end else begin
         verdict.status         = rhc_pkg::ST_OK;
         verdict.cause          = rhc_pkg::CAUSE_NONE;
         verdict.accept         = 1'b1;
         verdict.payload_length = total_length - HDR_LEN;
      end
   end

endmodule

[sv/readout_header_checker.sv]
// ----------------------------------------------------------------------------
// readout_header_checker
// Validates extracted readout datagram headers and tracks per-queue sequence.
// ----------------------------------------------------------------------------
// The checker takes one header beat per clock cycle while req_stall is low
// and returns one result beat for each, in order, when the result side is
// not stalled. A result passes through the input register, which also
// launches the read of the expected-sequence table, and the result register.
// Checks run in a fixed order and the first failure sets the status and
// the detailed cause. An accepted datagram is compared with the expected
// sequence of its queue and the table then holds its sequence plus one.
// The table sits in a RAM with one valid bit per queue, cleared by reset, so
// a queue never written reads as zero and no clearing pass is needed. The
// expected type register may be written through the csr port only while
// the block is idle; csr_ready is always high.
// ----------------------------------------------------------------------------
module readout_header_checker #(
   parameter int QUEUE_COUNT  = 32,
   parameter int HEADER_BYTES = 30
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_expected_type,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_buffer_present,
   input  logic [13:0] req_packet_size,
   input  logic [7:0]  req_pad_byte,
   input  logic [7:0]  req_version_byte,
   input  logic [23:0] req_cookie_word,
   input  logic [7:0]  req_packet_type,
   input  logic [15:0] req_total_length,
   input  logic [7:0]  req_queue_index,
   input  logic [31:0] req_sequence_number,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_fault_cause,
   output logic        rsp_sequence_mismatch,
   output logic [15:0] rsp_payload_length
);

   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

   // Configuration register.
   logic [7:0] expected_type_ff;

   // Input stage: captured header beat plus table lookup context.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_buffer_present_ff;
   logic [13:0] s1_packet_size_ff;
   logic [7:0]  s1_pad_byte_ff;
   logic [7:0]  s1_version_byte_ff;
   logic [23:0] s1_cookie_word_ff;
   logic [7:0]  s1_packet_type_ff;
   logic [15:0] s1_total_length_ff;
   logic [7:0]  s1_queue_index_ff;
   logic [31:0] s1_sequence_number_ff;
   logic        s1_entry_valid_ff;
   logic        s1_fwd_hit_ff;
   logic [31:0] s1_fwd_data_ff;

   // Result stage.
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff;
   logic [3:0]  out_fault_cause_ff;
   logic        out_mismatch_ff;
   logic [15:0] out_payload_length_ff;

   // Expected-sequence table.
   logic [QUEUE_COUNT-1:0] entry_valid_ff;
   logic [31:0]            table_rd_data;
   logic                   table_we;
   logic [QW-1:0]          table_wr_addr;
   logic [31:0]            table_wr_data;
   logic [QW-1:0]          table_rd_addr;

   logic                 s1_advance;
   logic                 req_accept;
   logic [31:0]          expected_seq;
   logic                 seq_mismatch;
   rhc_pkg::verdict_type verdict;

   assign csr_ready = 1'b1;

   // The input stage moves on whenever the result register is free or drained.
   assign s1_advance = !out_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;

   rhc_check #(
      .QUEUE_COUNT  (QUEUE_COUNT),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_check (
      .buffer_present (s1_buffer_present_ff),
      .packet_size    (s1_packet_size_ff),
      .pad_byte       (s1_pad_byte_ff),
      .version_byte   (s1_version_byte_ff),
      .cookie_word    (s1_cookie_word_ff),
      .packet_type    (s1_packet_type_ff),
      .total_length   (s1_total_length_ff),
      .queue_index    (s1_queue_index_ff),
      .expected_type  (expected_type_ff),
      .verdict        (verdict)
   );

   // The table is read when a beat is accepted. A write by the beat leaving
   // the input stage on that same edge is not seen by the read, so it is
   // forwarded. A queue that was never written expects zero.
   always_comb begin
      if (s1_fwd_hit_ff) begin
         expected_seq = s1_fwd_data_ff;
      end else if (s1_entry_valid_ff) begin
         expected_seq = table_rd_data;
      end else begin
         expected_seq = '0;
      end
   end

   assign seq_mismatch  = verdict.accept && (expected_seq != s1_sequence_number_ff);
   assign table_we      = s1_valid_ff && s1_advance && verdict.accept;
   assign table_wr_addr = s1_queue_index_ff[QW-1:0];
   assign table_wr_data = s1_sequence_number_ff + 32'd1;
   assign table_rd_addr = req_queue_index[QW-1:0];

   rhc_ram #(
      .WIDTH (32),
      .DEPTH (QUEUE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (table_wr_addr),
      .wr_data (table_wr_data),
      .rd_en   (req_accept),
      .rd_addr (table_rd_addr),
      .rd_data (table_rd_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= '0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         entry_valid_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            expected_type_ff <= csr_expected_type;
         end
         if (table_we) begin
            entry_valid_ff[table_wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_buffer_present_ff  <= req_buffer_present;
         s1_packet_size_ff     <= req_packet_size;
         s1_pad_byte_ff        <= req_pad_byte;
         s1_version_byte_ff    <= req_version_byte;
         s1_cookie_word_ff     <= req_cookie_word;
         s1_packet_type_ff     <= req_packet_type;
         s1_total_length_ff    <= req_total_length;
         s1_queue_index_ff     <= req_queue_index;
         s1_sequence_number_ff <= req_sequence_number;
         s1_entry_valid_ff     <= entry_valid_ff[table_rd_addr];
         s1_fwd_hit_ff         <= table_we && (table_wr_addr == table_rd_addr);
         s1_fwd_data_ff        <= table_wr_data;
      end
      if (s1_advance && s1_valid_ff) begin
         out_status_ff         <= verdict.status;
         out_fault_cause_ff    <= verdict.cause;
         out_mismatch_ff       <= seq_mismatch;
         out_payload_length_ff <= verdict.payload_length;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_fault_cause       = out_fault_cause_ff;
   assign rsp_sequence_mismatch = out_mismatch_ff;
   assign rsp_payload_length    = out_payload_length_ff;

`ifndef SYNTHESIS
   // An ok result carries no cause, and a failure carries one.
   a_ok_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == rhc_pkg::ST_OK) == (rsp_fault_cause == rhc_pkg::CAUSE_NONE)))
      else $error("status and fault cause disagree");

   // Only an accepted datagram reports a sequence mismatch or a payload.
   a_reject_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rhc_pkg::ST_OK)
         |-> (!rsp_sequence_mismatch && rsp_payload_length == 16'd0))
      else $error("rejected datagram reports mismatch or payload");

   // A table write marks its queue as holding a value.
   a_entry_marked : assert property (@(posedge clock) disable iff (reset)
      table_we |=> entry_valid_ff[$past(table_wr_addr)])
      else $error("table write did not mark its entry");

   // The table is written only when a result is loaded into the output stage.
   a_write_loads : assert property (@(posedge clock) disable iff (reset)
      table_we |=> rsp_valid)
      else $error("table written without a result");

   // Reset leaves no result pending.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result pending after reset");
`endif

endmodule

[tb/sv/header_verdict_monitor.sv]
// ----------------------------------------------------------------------------
// header_verdict_monitor
// Watches the header checker's channels, predicts each verdict and compares.
// ----------------------------------------------------------------------------
// Every header beat taken on the request channel is judged here against a
// private copy of the expected type and of the per-queue sequence table.
// Result beats must match the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module header_verdict_monitor
   import rhc_pkg::*;
#(
   parameter int QUEUE_COUNT  = 32,
   parameter int HEADER_BYTES = 30
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_expected_type,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_buffer_present,
   input  logic [13:0] req_packet_size,
   input  logic [7:0]  req_pad_byte,
   input  logic [7:0]  req_version_byte,
   input  logic [23:0] req_cookie_word,
   input  logic [7:0]  req_packet_type,
   input  logic [15:0] req_total_length,
   input  logic [7:0]  req_queue_index,
   input  logic [31:0] req_sequence_number,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [3:0]  rsp_fault_cause,
   input  logic        rsp_sequence_mismatch,
   input  logic [15:0] rsp_payload_length,

   output int          mismatch_count,
   output int          verdicts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

   typedef struct {
      status_type  status;
      cause_type   cause;
      logic        seq_mismatch;
      logic [15:0] payload;
   } verdict_t;

   logic [7:0]  type_setting;
   logic [31:0] seq_expected [QUEUE_COUNT];
   verdict_t    expected_verdicts [$];

   // The first failing check decides the verdict.
   function automatic verdict_t judge_header(
      input logic        present,
      input logic [13:0] size,
      input logic [7:0]  pad,
      input logic [7:0]  version,
      input logic [23:0] cookie,
      input logic [7:0]  ptype,
      input logic [15:0] total,
      input logic [7:0]  queue,
      input logic [31:0] seq
   );
      verdict_t v;
      v.status       = ST_OK;
      v.cause        = CAUSE_NONE;
      v.seq_mismatch = 1'b0;
      v.payload      = 16'd0;
      if (!present || size == 14'd0) begin
         v.status = ST_NO_BUFFER;
         v.cause  = CAUSE_BUFFER;
      end else if (size < SIZE_MIN || size > SIZE_MAX) begin
         v.status = ST_SIZE_ERR;
         v.cause  = CAUSE_SIZE;
      end else if (pad != PAD_VALUE) begin
         v.status = ST_HDR_ERR;
         v.cause  = CAUSE_PAD;
      end else if (version != VERSION_VALUE) begin
         v.status = ST_HDR_ERR;
         v.cause  = CAUSE_VERSION;
      end else if (cookie != COOKIE_VALUE) begin
         v.status = ST_HDR_ERR;
         v.cause  = CAUSE_COOKIE;
      end else if (size < HEADER_BYTES) begin
         v.status = ST_SIZE_ERR;
         v.cause  = CAUSE_SIZE;
      end else if (total > size || total < HEADER_BYTES) begin
         v.status = ST_SIZE_ERR;
         v.cause  = CAUSE_LENGTH;
      end else if (ptype != type_setting) begin
         v.status = ST_HDR_ERR;
         v.cause  = CAUSE_TYPE;
      end else if (queue >= QUEUE_COUNT) begin
         v.status = ST_HDR_ERR;
         v.cause  = CAUSE_QUEUE;
      end else begin
         v.seq_mismatch = (seq_expected[queue[QW-1:0]] != seq);
         v.payload      = 16'(total - HEADER_BYTES);
      end
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      verdict_t v;
      verdict_t want;
      if (reset) begin
         type_setting = 8'd0;
         foreach (seq_expected[i])
            seq_expected[i] = 32'd0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready)
            type_setting = csr_expected_type;

         if (req_valid && !req_stall) begin
            v = judge_header(req_buffer_present, req_packet_size, req_pad_byte,
                             req_version_byte, req_cookie_word, req_packet_type,
                             req_total_length, req_queue_index, req_sequence_number);
            // Only an accepted datagram moves its queue's expected sequence.
            if (v.status == ST_OK)
               seq_expected[req_queue_index[QW-1:0]] = req_sequence_number + 32'd1;
            expected_verdicts.push_back(v);
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result beat with no header beat waiting");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_status, want.status.name()));
               if (rsp_fault_cause !== want.cause)
                  report_mismatch($sformatf("fault_cause %0d, expected %s",
                                            rsp_fault_cause, want.cause.name()));
               if (rsp_sequence_mismatch !== want.seq_mismatch)
                  report_mismatch($sformatf("sequence_mismatch %b, expected %b",
                                            rsp_sequence_mismatch, want.seq_mismatch));
               if (rsp_payload_length !== want.payload)
                  report_mismatch($sformatf("payload_length %0d, expected %0d",
                                            rsp_payload_length, want.payload));
            end
         end
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

[tb/sv/readout_header_checker_test.sv]
// ----------------------------------------------------------------------------
// readout_header_checker_test
// Stimulus and verdict for the readout header checker.
// ----------------------------------------------------------------------------
// A short directed set walks every check of the header in order, both size
// limits and the sequence wrap. Random headers follow, mostly well formed
// with tracked sequence numbers, the rest carrying one or two faults or pure
// noise. The expected type is rewritten between phases while the block is
// idle. The monitor beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module readout_header_checker_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rhc_pkg::*;

   localparam int QUEUE_COUNT  = 32;
   localparam int HEADER_BYTES = 30;
   localparam int PHASE_COUNT  = 5;
   localparam int PHASE_BEATS  = 320;
   localparam int CYCLE_LIMIT  = 200000;

   // One header beat as it appears on the request channel.
   typedef struct packed {
      logic        buffer_present;
      logic [13:0] packet_size;
      logic [7:0]  pad_byte;
      logic [7:0]  version_byte;
      logic [23:0] cookie_word;
      logic [7:0]  packet_type;
      logic [15:0] total_length;
      logic [7:0]  queue_index;
      logic [31:0] sequence_number;
   } header_beat_t;

   // Ways a random header is spoiled; noise randomizes every field.
   typedef enum int {
      F_NO_BUFFER,
      F_EMPTY,
      F_TINY,
      F_OVERSIZE,
      F_PAD,
      F_VERSION,
      F_COOKIE,
      F_SHORT,
      F_LENGTH,
      F_TYPE,
      F_QUEUE,
      F_NOISE
   } fault_kind_t;

   logic        clock;
   logic        reset;

   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_expected_type;

   logic        req_valid;
   logic        req_stall;
   logic        req_buffer_present;
   logic [13:0] req_packet_size;
   logic [7:0]  req_pad_byte;
   logic [7:0]  req_version_byte;
   logic [23:0] req_cookie_word;
   logic [7:0]  req_packet_type;
   logic [15:0] req_total_length;
   logic [7:0]  req_queue_index;
   logic [31:0] req_sequence_number;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_fault_cause;
   logic        rsp_sequence_mismatch;
   logic [15:0] rsp_payload_length;

   int          mismatch_count;
   int          verdicts_pending;
   int          cycle_count;

   // Idling on both channels is allowed only while this is set.
   bit          idling_on = 1'b1;
   // Type the stimulus treats as correct; follows every register write.
   logic [7:0]  current_type = 8'd0;
   // Next sequence number per queue, used so that most good headers line up.
   // This only shapes the stimulus; the monitor keeps its own table.
   logic [31:0] seq_hint [QUEUE_COUNT] = '{default: 32'd0};

   readout_header_checker #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .HEADER_BYTES(HEADER_BYTES)
   ) dut (.*);

   header_verdict_monitor #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .HEADER_BYTES(HEADER_BYTES)
   ) monitor (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The run is cut off here if the handshakes ever stop moving.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("readout_header_checker test failed");
      $finish;
   end

   // Result side: the stall comes in short random bursts while idling is on.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && !reset && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // A header that passes every check, with random size and total length.
   function automatic header_beat_t well_formed(input int unsigned queue,
                                                input logic [31:0] seq);
      header_beat_t hb;
      hb.buffer_present  = 1'b1;
      hb.packet_size     = 14'($urandom_range(HEADER_BYTES, SIZE_MAX));
      hb.pad_byte        = PAD_VALUE;
      hb.version_byte    = VERSION_VALUE;
      hb.cookie_word     = COOKIE_VALUE;
      hb.packet_type     = current_type;
      hb.total_length    = 16'($urandom_range(HEADER_BYTES, hb.packet_size));
      hb.queue_index     = 8'(queue);
      hb.sequence_number = seq;
      return hb;
   endfunction

   // Drives one header beat and returns at the edge that takes it. The valid
   // stays high into the next beat unless an idle burst comes first.
   task automatic send_header(input header_beat_t hb);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_buffer_present  <= hb.buffer_present;
      req_packet_size     <= hb.packet_size;
      req_pad_byte        <= hb.pad_byte;
      req_version_byte    <= hb.version_byte;
      req_cookie_word     <= hb.cookie_word;
      req_packet_type     <= hb.packet_type;
      req_total_length    <= hb.total_length;
      req_queue_index     <= hb.queue_index;
      req_sequence_number <= hb.sequence_number;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Stops the input side and waits until every verdict is back before
   // anything else.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_expected_type(input logic [7:0] value);
      csr_valid         <= 1'b1;
      csr_expected_type <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid    <= 1'b0;
      current_type  = value;
   endtask

   task automatic inject_fault(inout header_beat_t hb);
      fault_kind_t kind;
      kind = fault_kind_t'($urandom_range(0, F_NOISE));
      case (kind)
         F_NO_BUFFER: hb.buffer_present = 1'b0;
         F_EMPTY:     hb.packet_size    = 14'd0;
         F_TINY:      hb.packet_size    = 14'($urandom_range(1, SIZE_MIN - 1));
         F_OVERSIZE:  hb.packet_size    = 14'($urandom_range(SIZE_MAX + 1, 14'h3FFF));
         F_PAD:       hb.pad_byte       = 8'($urandom_range(1, 255));
         F_VERSION:   hb.version_byte   = 8'($urandom_range(1, 255));
         F_COOKIE:    hb.cookie_word    = COOKIE_VALUE ^ 24'($urandom_range(1, 24'hFFFFFF));
         F_SHORT:     hb.packet_size    = 14'($urandom_range(SIZE_MIN, HEADER_BYTES - 1));
         F_LENGTH: begin
            // Either longer than the datagram or shorter than the header.
            if ($urandom_range(0, 1) == 0)
               hb.total_length = 16'($urandom_range(hb.packet_size + 1, 16'hFFFF));
            else
               hb.total_length = 16'($urandom_range(0, HEADER_BYTES - 1));
         end
         F_TYPE:      hb.packet_type    = current_type ^ 8'($urandom_range(1, 255));
         F_QUEUE:     hb.queue_index    = 8'($urandom_range(QUEUE_COUNT, 255));
         default: begin
            hb.buffer_present  = 1'($urandom);
            hb.packet_size     = 14'($urandom);
            hb.pad_byte        = 8'($urandom);
            hb.version_byte    = 8'($urandom);
            hb.cookie_word     = 24'($urandom);
            hb.packet_type     = 8'($urandom);
            hb.total_length    = 16'($urandom);
            hb.queue_index     = 8'($urandom);
            hb.sequence_number = $urandom;
         end
      endcase
   endtask

   // Just over half the random headers are well formed, and most of those
   // carry the sequence number their queue is waiting for. The rest get one
   // or two faults, so that the order of the checks is exercised as well.
   task automatic make_random_header(output header_beat_t hb);
      int unsigned queue;
      logic [31:0] seq;
      int unsigned pick;
      if ($urandom_range(0, 99) < 55) begin
         queue = $urandom_range(0, QUEUE_COUNT - 1);
         pick  = $urandom_range(0, 9);
         if (pick == 0)
            seq = $urandom;
         else if (pick == 1)
            seq = 32'hFFFF_FFFF;
         else
            seq = seq_hint[queue];
         hb = well_formed(queue, seq);
         seq_hint[queue] = seq + 32'd1;
      end else begin
         hb = well_formed($urandom_range(0, QUEUE_COUNT - 1), $urandom);
         inject_fault(hb);
         if ($urandom_range(0, 2) == 0)
            inject_fault(hb);
      end
   endtask

   // Directed headers, sent with the expected type at its reset value. Most
   // rejected ones use queue 5, which no accepted directed header touches.
   task automatic run_directed();
      header_beat_t hb;
      // No buffer, and an empty buffer.
      hb = well_formed(5, 0); hb.buffer_present = 1'b0; send_header(hb);
      hb = well_formed(5, 0); hb.packet_size = 14'd0; send_header(hb);
      // Size just under the minimum, just over the maximum, and the top code.
      hb = well_formed(5, 0); hb.packet_size = SIZE_MIN - 14'd1; send_header(hb);
      hb = well_formed(5, 0); hb.packet_size = SIZE_MAX + 14'd1; send_header(hb);
      hb = well_formed(5, 0); hb.packet_size = 14'h3FFF; send_header(hb);
      // Header byte faults.
      hb = well_formed(5, 0); hb.pad_byte = 8'hFF; send_header(hb);
      hb = well_formed(5, 0); hb.version_byte = 8'hFF; send_header(hb);
      hb = well_formed(5, 0); hb.cookie_word = 24'hFFFFFF; send_header(hb);
      hb = well_formed(5, 0); hb.cookie_word = 24'h000000; send_header(hb);
      // Datagrams too short to hold the header, at both ends of that range.
      hb = well_formed(5, 0); hb.packet_size = SIZE_MIN; hb.total_length = 16'd5;
      send_header(hb);
      hb = well_formed(5, 0); hb.packet_size = 14'(HEADER_BYTES - 1); send_header(hb);
      // Total length below the header, just past the size, and at its maximum.
      hb = well_formed(5, 0); hb.packet_size = 14'd100;
      hb.total_length = 16'(HEADER_BYTES - 1); send_header(hb);
      hb = well_formed(5, 0); hb.packet_size = 14'd100; hb.total_length = 16'd101;
      send_header(hb);
      hb = well_formed(5, 0); hb.total_length = 16'hFFFF; send_header(hb);
      // Wrong type, and queues just past the end and at the top.
      hb = well_formed(5, 0); hb.packet_type = 8'hFF; send_header(hb);
      hb = well_formed(5, 0); hb.queue_index = 8'(QUEUE_COUNT); send_header(hb);
      hb = well_formed(5, 0); hb.queue_index = 8'hFF; send_header(hb);
      // Largest accepted datagram on the last queue.
      hb = well_formed(QUEUE_COUNT - 1, 0); hb.packet_size = SIZE_MAX;
      hb.total_length = 16'(SIZE_MAX); send_header(hb);
      // Smallest accepted datagram: a bare header with no payload.
      hb = well_formed(0, 0); hb.packet_size = 14'(HEADER_BYTES);
      hb.total_length = 16'(HEADER_BYTES); send_header(hb);
      // A jump in the sequence, then the number that follows it.
      hb = well_formed(0, 32'd5); send_header(hb);
      hb = well_formed(0, 32'd6); send_header(hb);
      // The stored value wraps from all ones to zero.
      hb = well_formed(1, 32'hFFFF_FFFF); send_header(hb);
      hb = well_formed(1, 32'd0); send_header(hb);
      // A rejected datagram must leave its queue's expected sequence alone.
      hb = well_formed(1, 32'd77); hb.packet_type = 8'h5A; send_header(hb);
      hb = well_formed(1, 32'd1); send_header(hb);
      seq_hint[0]               = 32'd7;
      seq_hint[1]               = 32'd2;
      seq_hint[QUEUE_COUNT - 1] = 32'd1;
   endtask

   initial begin
      header_beat_t hb;
      logic [7:0]   type_plan [PHASE_COUNT];

      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_expected_type   = 8'd0;
      req_valid           = 1'b0;
      req_buffer_present  = 1'b0;
      req_packet_size     = 14'd0;
      req_pad_byte        = 8'd0;
      req_version_byte    = 8'd0;
      req_cookie_word     = 24'd0;
      req_packet_type     = 8'd0;
      req_total_length    = 16'd0;
      req_queue_index     = 8'd0;
      req_sequence_number = 32'd0;

      // The first phase runs on the reset value of the type register; the
      // later ones cover both extremes and a random value in between.
      type_plan[0] = 8'h00;
      type_plan[1] = 8'hFF;
      type_plan[2] = 8'($urandom_range(1, 254));
      type_plan[3] = 8'h00;
      type_plan[4] = 8'h80;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            drain_results();
            write_expected_type(type_plan[phase]);
         end
         if (phase == 0)
            run_directed();
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // Idling comes and goes in stretches; the last phase runs flat out.
            idling_on = (phase < PHASE_COUNT - 1) && ((i / 40) % 4 != 3);
            make_random_header(hb);
            send_header(hb);
         end
      end

      drain_results();

      if (mismatch_count == 0 && verdicts_pending == 0)
         $display("readout_header_checker test passed");
      else
         $display("readout_header_checker test failed");
      $finish;
   end

endmodule

[files.f]
sv/rhc_pkg.sv
sv/rhc_ram.sv
sv/rhc_check.sv
sv/readout_header_checker.sv
tb/sv/header_verdict_monitor.sv
tb/sv/readout_header_checker_test.sv
